// File: src/mt_pkg.sv
// shared types, constants and word functions for the mt19937 generator
`timescale 1ns / 1ps

package mt_pkg;

  localparam int STATE_WORDS     = 624;
  localparam int SHIFT_OFFSET    = 397;
  localparam int FAR_BACK        = STATE_WORDS - SHIFT_OFFSET;
  localparam int IDX_W           = $clog2(STATE_WORDS);
  localparam int WORD_W          = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [WORD_W-1:0] MATRIX_A     = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;
  localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;

  // one queued request
  typedef struct packed {
    logic reseed;
  } cmd_t;

  // engine status seen by the top level
  typedef struct packed {
    logic busy;
    logic drawing;
  } back_sts_t;

  function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] upper,
                                                   input logic [WORD_W-1:0] lower,
                                                   input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] mag;
    y   = (upper & HIGH_BIT) | (lower & LOW_BITS);
    mag = y[0] ? MATRIX_A : '0;
    return far ^ (y >> 1) ^ mag;
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] t;
    t = x;
    t = t ^ (t >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

endpackage

// File: src/mt_front.sv
// request front end: seed register, reseed classification and queue push
`timescale 1ns / 1ps

module mt_front
  import mt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_restart,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd,
  output logic [WORD_W-1:0] seed_word
);

  logic [WORD_W-1:0] seed_r;
  logic              seeded_r;

  assign in_stall     = q_full;
  assign q_push       = in_valid && !q_full;
  // the first word after reset always reseeds
  assign q_cmd.reseed = in_restart || !seeded_r;
  assign seed_word    = (seed_r == '0) ? DEFAULT_SEED : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= DEFAULT_SEED;
      seeded_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
      if (q_push) begin
        seeded_r <= 1'b1;
      end
    end
  end

endmodule

// File: src/mt_cmd_fifo.sv
// short request queue between front end and engine
`timescale 1ns / 1ps

module mt_cmd_fifo
  import mt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// File: src/mt_back.sv
// engine: state memory, seeding, twist sweep, tempering and output word
`timescale 1ns / 1ps

module mt_back
  import mt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  input  logic [WORD_W-1:0] seed_word,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_random_word,
  output back_sts_t         sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED_MUL,
    S_SEED_ADD,
    S_CHECK,
    S_TW_LOAD,
    S_TW_ISSUE,
    S_TW_CALC,
    S_DRAW
  } state_t;

  state_t            state_r;
  logic [IDX_W-1:0]  widx_r;
  logic [IDX_W-1:0]  cnt_r;
  logic [WORD_W-1:0] p_r;
  logic [WORD_W-1:0] prod_r;
  logic [WORD_W-1:0] cur_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;

  logic [WORD_W-1:0] mem_r [STATE_WORDS];
  logic [WORD_W-1:0] rd_a_q;
  logic [WORD_W-1:0] rd_b_q;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  addr_a;
  logic [IDX_W-1:0]  addr_b;
  logic [IDX_W-1:0]  next_idx;
  logic [IDX_W-1:0]  far_idx;
  logic [WORD_W-1:0] seed_next;
  logic              index_spent;
  logic              cnt_last;
  logic              out_free;

  assign next_idx    = (cnt_r == IDX_W'(STATE_WORDS - 1)) ? '0 : cnt_r + IDX_W'(1);
  assign far_idx     = (cnt_r >= IDX_W'(FAR_BACK)) ? cnt_r - IDX_W'(FAR_BACK)
                                                  : cnt_r + IDX_W'(SHIFT_OFFSET);
  assign seed_next   = prod_r + WORD_W'(cnt_r);
  assign index_spent = (widx_r == IDX_W'(STATE_WORDS));
  assign cnt_last    = (cnt_r == IDX_W'(STATE_WORDS - 1));
  assign out_free    = !out_valid_r || !out_stall;
  assign cmd_pop     = (state_r == S_IDLE) && cmd_valid;

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;
  assign sts.busy        = (state_r != S_IDLE);
  assign sts.drawing     = (state_r == S_DRAW);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = seed_next;
    addr_a    = widx_r;
    addr_b    = far_idx;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && cmd.reseed) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = seed_word;
        end
      end
      S_SEED_ADD: begin
        mem_we = 1'b1;
      end
      S_CHECK: begin
        addr_a = index_spent ? '0 : widx_r;
      end
      S_TW_ISSUE: begin
        addr_a = next_idx;
      end
      S_TW_CALC: begin
        mem_we    = 1'b1;
        mem_wdata = twist_word(cur_r, rd_a_q, rd_b_q);
      end
      S_SEED_MUL, S_TW_LOAD, S_DRAW: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= mem_r[addr_a];
    rd_b_q <= mem_r[addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      widx_r      <= IDX_W'(STATE_WORDS);
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.reseed) begin
              p_r     <= seed_word;
              cnt_r   <= IDX_W'(1);
              state_r <= S_SEED_MUL;
            end else begin
              state_r <= S_CHECK;
            end
          end
        end
        S_SEED_MUL: begin
          prod_r  <= SEED_MULT * (p_r ^ (p_r >> 30));
          state_r <= S_SEED_ADD;
        end
        S_SEED_ADD: begin
          p_r <= seed_next;
          if (cnt_last) begin
            widx_r  <= IDX_W'(STATE_WORDS);
            state_r <= S_CHECK;
          end else begin
            cnt_r   <= cnt_r + IDX_W'(1);
            state_r <= S_SEED_MUL;
          end
        end
        S_CHECK: begin
          if (index_spent) begin
            cnt_r   <= '0;
            state_r <= S_TW_LOAD;
          end else begin
            state_r <= S_DRAW;
          end
        end
        S_TW_LOAD: begin
          cur_r   <= rd_a_q;
          state_r <= S_TW_ISSUE;
        end
        S_TW_ISSUE: begin
          state_r <= S_TW_CALC;
        end
        S_TW_CALC: begin
          // the word read ahead becomes the upper word of the next step
          cur_r <= rd_a_q;
          if (cnt_last) begin
            widx_r  <= '0;
            state_r <= S_CHECK;
          end else begin
            cnt_r   <= cnt_r + IDX_W'(1);
            state_r <= S_TW_ISSUE;
          end
        end
        S_DRAW: begin
          if (out_free) begin
            out_word_r  <= temper(rd_a_q);
            out_valid_r <= 1'b1;
            widx_r      <= widx_r + IDX_W'(1);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/mt19937_generator_core.sv
// top level of the mt19937 random word generator
`timescale 1ns / 1ps

// MT19937 generator, one tempered 32-bit word per request word.
// Request channel in_valid/in_stall carries in_restart; a set restart, or the
// first request after reset, refills the 624-word state from the seed.
// Result channel out_valid/out_stall carries out_random_word, one per request.
// cfg_we writes cfg_wdata to the seed register (0 acts as 4357); it takes
// effect at the next reseed. The user must write it only while the block is
// idle; the block does not enforce this. Requests go into a small queue, so
// new words are taken while a result waits. A plain draw passes the queue,
// then S_IDLE, S_CHECK and S_DRAW; the engine takes one request at a time.
// A reseed writes word 0 from the seed, then S_SEED_MUL and S_SEED_ADD for
// each further state word. Every 624th word adds a twist sweep: S_TW_LOAD,
// then S_TW_ISSUE and S_TW_CALC for each of the 624 state words.
// Reset (rst_n low, synchronous) empties the queue, clears the output and
// sets the seed to 4357; the state memory is not cleared.
// While out_stall holds a valid result, the word holds and S_DRAW waits.

module mt19937_generator_core
  import mt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_restart,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_random_word,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata
);

  logic              q_full;
  logic              q_push;
  cmd_t              q_cmd;
  logic              cmd_valid;
  cmd_t              cmd;
  logic              cmd_pop;
  logic [WORD_W-1:0] seed_word;
  back_sts_t         sts;

  mt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_restart(in_restart),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .seed_word (seed_word)
  );

  mt_cmd_fifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (cmd_pop),
    .pop_valid(cmd_valid),
    .pop_cmd  (cmd)
  );

  mt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .seed_word      (seed_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_random_word(out_random_word),
    .sts            (sts)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("engine popped an empty queue");

  a_pop_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> sts.busy)
    else $error("engine idle after taking a request");

  a_word_from_draw: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(sts.drawing))
    else $error("result word appeared outside a draw");

endmodule
